[design/asrch_pkg.sv]
// ============================================================================
// asrch_pkg
// Shared types, codes and field widths of the array search block.
// ============================================================================
package asrch_pkg;

  // Default sizes of the element store.
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the item fields on the ports.
  localparam int CMD_W      = 2;
  localparam int VALUE_IN_W = 32;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 10;
  localparam int STEPS_W    = 11;
  localparam int OUT_DATA_W = 24;

  // Command codes carried with each input item.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;     // latch the target and set up the search window
    logic    clear;     // empty the store
    logic    append;    // write the incoming word at the end of the store
    logic    probe;     // issue a store read and count one probe
    logic    narrow;    // shrink the window after a mismatch
    logic    load_out;  // move the finished result into the output register
    status_t status;    // status of the finished result
  } asrch_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;      // store holds STORE_DEPTH words
    logic active;    // search window is not empty
    logic match;     // word read back equals the target
    logic out_free;  // output register can take a result this cycle
  } asrch_sts_t;

endpackage

[design/array_search_with_step_count.sv]
// ============================================================================
// array_search_with_step_count
// Word store with clear, append and search items; reports the probe count.
// ============================================================================
// The block keeps up to STORE_DEPTH signed words. A clear item empties the
// store, an append item adds its word at the end (or reports store full), and
// a search item looks for its word, by linear scan from index 0 when the mode
// register is 0 or by binary search over an ascending store when it is 1.
// Each item returns exactly one result item. A clear or append item goes
// from the accepting cycle to a finishing state, which loads the result
// once the output register is free. A search alternates a read state and a
// compare state per probe, since each probe is a read of the store with a
// registered output followed by a compare, and goes to the finishing state
// on a match or when the search window is empty. One item is worked on at a
// time; a finished result waits in the output register, so the next item can
// be accepted while the previous result has not been taken. The mode register
// should be written only while the block is idle.
// ============================================================================
module array_search_with_step_count
  import asrch_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: search_mode (0 linear scan, 1 binary search).
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_IN_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]      s_axis_tuser,   // [1:0] command
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] found_index, [20:10] steps_taken
  output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  asrch_cmd_t             cmd;
  asrch_sts_t             sts;
  logic [INDEX_W-1:0]     out_index;
  logic [STEPS_W-1:0]     out_steps;

  // The mode register is a plain flop and takes a write in any cycle.
  assign cfg_ready = 1'b1;

  asrch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .command  (s_axis_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  asrch_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .value      (s_axis_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_index  (out_index),
    .out_steps  (out_steps)
  );

  // Result payload packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata = {(OUT_DATA_W - INDEX_W - STEPS_W)'(0), out_steps, out_index};

  // A result is only loaded when the output register can take it.
  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // A probe is only issued while the search window is not empty.
  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |-> sts.active)
    else $error("probe issued outside the search window");

  // Only a found result carries a nonzero index.
  a_index_only_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> (out_index == '0))
    else $error("nonzero index on a result that is not a match");

  // A match always takes at least one probe.
  a_found_has_steps: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FOUND) |-> (out_steps != '0))
    else $error("match reported with zero probes");

endmodule

[design/asrch_ram.sv]
// ============================================================================
// asrch_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ============================================================================
module asrch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/asrch_dp.sv]
// ============================================================================
// asrch_dp
// Datapath: element store, element count, search window, probe counter,
// mode register and output register.
// ============================================================================
module asrch_dp
  import asrch_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_data,
  input  logic [VALUE_IN_W-1:0] value,
  input  asrch_cmd_t            cmd,
  output asrch_sts_t            sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [INDEX_W-1:0]    out_index,
  output logic [STEPS_W-1:0]    out_steps
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic                          search_mode;
  logic [CW-1:0]                 count;
  logic signed [VALUE_WIDTH-1:0] key;
  logic signed [VALUE_WIDTH-1:0] value_ext;
  logic signed [VALUE_WIDTH-1:0] word;
  logic [CW-1:0]                 lo;
  logic [CW-1:0]                 hi_x;      // one past the window's last index
  logic [CW-1:0]                 steps;
  logic [IW-1:0]                 probe_addr;
  logic [IW-1:0]                 probe_next;
  logic [CW:0]                   mid_sum;
  logic [VALUE_WIDTH-1:0]        rdata;

  // The input word is sign-extended or truncated to the store width.
  assign value_ext = VALUE_WIDTH'($signed(value));
  assign word      = $signed(rdata);

  // Floored midpoint of lo and the last index (hi_x - 1).
  assign mid_sum    = {1'b0, lo} + {1'b0, hi_x} - (CW + 1)'(1);
  assign probe_next = search_mode ? mid_sum[IW:1] : lo[IW-1:0];

  asrch_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count[IW-1:0]),
    .wdata (value_ext),
    .re    (cmd.probe),
    .raddr (probe_next),
    .rdata (rdata)
  );

  assign sts.full     = (count == CW'(STORE_DEPTH));
  assign sts.active   = (lo < hi_x);
  assign sts.match    = (word == key);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode <= 1'b0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        search_mode <= cfg_data;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key   <= value_ext;
      lo    <= '0;
      hi_x  <= count;
      steps <= '0;
    end
    if (cmd.probe) begin
      probe_addr <= probe_next;
      steps      <= steps + CW'(1);
    end
    // Linear scan always moves up; binary search moves up when the probed
    // word is below the target and down otherwise.
    if (cmd.narrow) begin
      if (!search_mode || (word < key)) begin
        lo <= CW'(probe_addr) + CW'(1);
      end else begin
        hi_x <= CW'(probe_addr);
      end
    end
    if (cmd.load_out) begin
      out_status <= cmd.status;
      out_index  <= (cmd.status == ST_FOUND) ? INDEX_W'(probe_addr) : '0;
      out_steps  <= STEPS_W'(steps);
    end
  end

endmodule

[design/asrch_ctrl.sv]
// ============================================================================
// asrch_ctrl
// Controller: decodes each item and sequences the probes of a search.
// ============================================================================
module asrch_ctrl
  import asrch_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  input  asrch_sts_t       sts,
  output asrch_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FINISH
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t result;
  status_t result_next;
  logic    accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    result_next  = result;
    cmd          = '0;
    cmd.status   = result;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          state_next = S_FINISH;
          result_next = ST_DONE;
          unique case (command)
            CMD_CLEAR: begin
              cmd.clear = 1'b1;
            end
            CMD_APPEND: begin
              if (sts.full) begin
                result_next = ST_FULL;
              end else begin
                cmd.append = 1'b1;
              end
            end
            CMD_SEARCH: begin
              state_next = S_READ;
            end
            default: begin
              result_next = ST_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        if (sts.active) begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end else begin
          result_next = ST_NOT_FOUND;
          state_next  = S_FINISH;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          result_next = ST_FOUND;
          state_next  = S_FINISH;
        end else begin
          cmd.narrow = 1'b1;
          state_next = S_READ;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      result <= ST_DONE;
    end else begin
      state  <= state_next;
      result <= result_next;
    end
  end

endmodule
